/* src/psc_pkg.sv */
// Shared types and constants of the PID speed controller.
// Used by the channel interfaces, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    // field widths
    localparam int SPEED_W  = 24;
    localparam int ERR_W    = 25;
    localparam int DIFF_W   = 26;
    localparam int EFFORT_W = 16;
    localparam int CLAMP_W  = 2;
    localparam int GAIN_W   = 32;
    localparam int RATE_W   = 17;
    localparam int LIMIT_W  = 15;
    localparam int INTEG_W  = 48;
    localparam int HALF_W   = 24;
    localparam int DERIV_W  = 43;

    // shared multiplier: 32b signed gain or difference by 25b signed operand
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LOOP_RATE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_EFFORT_LIMIT = 3'd4;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 17'd1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd4095;

    // clamp flag codes
    localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
    localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

    localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // multiplier operations, issued in this order
    typedef enum logic [2:0] {
        OP_DER,
        OP_P,
        OP_IL,
        OP_IH,
        OP_DL,
        OP_DH
    } mul_op_t;

    localparam logic [2:0] MUL_STEPS = 3'd6;

endpackage

`default_nettype wire

/* src/psc_if.sv */
// Channel interfaces of the PID speed controller: sample, result, config.
// Depends on psc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface psc_sample_if
    import psc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] target_speed;
    logic signed [SPEED_W-1:0] measured_speed;
    logic                      clear;

    modport source (output valid, output target_speed, output measured_speed,
                    output clear, input ready);
    modport sink   (input valid, input target_speed, input measured_speed,
                    input clear, output ready);
endinterface

interface psc_result_if
    import psc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [EFFORT_W-1:0] drive_effort;
    logic signed [ERR_W-1:0]    speed_error;
    logic [CLAMP_W-1:0]         clamp_state;

    modport source (output valid, output drive_effort, output speed_error,
                    output clamp_state, input ready);
    modport sink   (input valid, input drive_effort, input speed_error,
                    input clamp_state, output ready);
endinterface

interface psc_cfg_if
    import psc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* src/pid_speed_controller_top.sv */
// Discrete PID speed controller with symmetric output clamp.
// Depends on psc_pkg and the channel interfaces in psc_if.sv.
//
// Usage:
//   sample : target/measured speed (Q15.8) and a clear bit, valid/ready.
//   result : drive effort, speed error and clamp flag, valid/ready.
//   cfg    : register writes (addr, data), always ready. Write only while
//            idle; any write to a listed register clears integrator and
//            last error. Writes past the list are ignored.
// Timing:
//   One word at a time. A word runs through the restoring divider (one
//   quotient bit per cycle, DIV_W = 24 + 16 - SPEED_FRAC_BITS bits, 32 at
//   default), then six passes through the one shared 32x25 multiplier,
//   before the result is valid. A clear word skips both. The next sample
//   is taken from the cycle after the result is handed to the output
//   register, even if the receiver has not yet taken it.
// Reset: gains 0, loop rate 1000, limit 4095, integrator and last error 0.
// Stall: a result waits in the output register; a following result waits
//   in its last sequencer state until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module pid_speed_controller_top
    import psc_pkg::*;
#(
    parameter int SPEED_FRAC_BITS = 8,
    parameter int GAIN_FRAC_BITS  = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    psc_sample_if.sink     sample,
    psc_result_if.source   result,
    psc_cfg_if.sink        cfg
);

    localparam int SPD_SHIFT = 16 - SPEED_FRAC_BITS;
    localparam int OUT_SHIFT = 16 + GAIN_FRAC_BITS;
    localparam int DIV_W     = HALF_W + SPD_SHIFT;   // |error| < 2^24
    localparam int DCNT_W    = $clog2(DIV_W);
    localparam int ACC_W     = (SPD_SHIFT > 5) ? 76 + SPD_SHIFT : 81;
    localparam int MAG_W     = ACC_W - OUT_SHIFT;
    localparam int SUM_W     = INTEG_W + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_INTEG = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_ABS   = 7'b0010000,
        S_CLAMP = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    // control and configuration
    state_t                     state_reg;
    logic [DCNT_W-1:0]          dcnt_reg;
    logic [2:0]                 mcnt_reg;
    logic                       prod_vld_reg;
    mul_op_t                    prod_op_reg;
    logic                       out_valid_reg;
    logic signed [GAIN_W-1:0]   gain_p_reg;
    logic signed [GAIN_W-1:0]   gain_i_reg;
    logic signed [GAIN_W-1:0]   gain_d_reg;
    logic [RATE_W-1:0]          rate_reg;
    logic [LIMIT_W-1:0]         limit_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [ERR_W-1:0]    prev_reg;

    // datapath
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [DERIV_W-1:0]  deriv_reg;
    logic [DIV_W-1:0]           div_reg;
    logic [RATE_W-1:0]          rem_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       neg_reg;
    logic signed [EFFORT_W-1:0] res_effort_reg;
    logic signed [ERR_W-1:0]    res_err_reg;
    logic [CLAMP_W-1:0]         res_clamp_reg;
    logic signed [EFFORT_W-1:0] out_effort_reg;
    logic signed [ERR_W-1:0]    out_err_reg;
    logic [CLAMP_W-1:0]         out_clamp_reg;

    logic                       sample_acc;
    logic                       cfg_acc;
    logic                       out_free;
    logic [RATE_W-1:0]          freq;
    logic signed [ERR_W-1:0]    err_in;
    logic [ERR_W-1:0]           err_mag;
    logic [DIV_W-1:0]           div_load;
    logic [RATE_W:0]            rem_sh;
    logic [RATE_W:0]            rem_diff;
    logic                       q_bit;
    logic [RATE_W-1:0]          rem_next;
    logic [DIV_W-1:0]           div_next;
    logic [SUM_W-1:0]           step_ext;
    logic [SUM_W-1:0]           step_s;
    logic [SUM_W-1:0]           integ_sum;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [DIFF_W-1:0]   diff_next;
    logic                       mul_issue;
    mul_op_t                    op_issue;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic [ACC_W-1:0]           prod_ext;
    logic [ACC_W-1:0]           term;
    logic signed [ACC_W-1:0]    acc_next;
    logic [MAG_W-1:0]           mag;
    logic                       over;
    logic [LIMIT_W-1:0]         mag_eff;
    logic [EFFORT_W-1:0]        eff_pos;
    logic signed [EFFORT_W-1:0] effort_next;
    logic [CLAMP_W-1:0]         clamp_next;

    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign sample_acc   = sample.valid & sample.ready;
    assign cfg_acc      = cfg.valid & cfg.ready;
    assign out_free     = !out_valid_reg || result.ready;

    assign result.valid        = out_valid_reg;
    assign result.drive_effort = out_effort_reg;
    assign result.speed_error  = out_err_reg;
    assign result.clamp_state  = out_clamp_reg;

    // zero loop rate counts as 1
    assign freq = (rate_reg == '0) ? RATE_W'(1) : rate_reg;

    // error and divider load
    assign err_in   = {sample.target_speed[SPEED_W-1], sample.target_speed}
                    - {sample.measured_speed[SPEED_W-1], sample.measured_speed};
    assign err_mag  = err_in[ERR_W-1] ? -err_in : err_in;
    assign div_load = DIV_W'(err_mag[HALF_W-1:0]) << SPD_SHIFT;

    // restoring division step, one quotient bit per cycle
    assign rem_sh   = {rem_reg, div_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, freq};
    assign q_bit    = (rem_sh >= {1'b0, freq});
    assign rem_next = q_bit ? rem_diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
    assign div_next = {div_reg[DIV_W-2:0], q_bit};

    // saturating integrator update
    assign step_ext  = SUM_W'(div_reg);
    assign step_s    = err_reg[ERR_W-1] ? -step_ext : step_ext;
    assign integ_sum = {integ_reg[INTEG_W-1], integ_reg} + step_s;

    always_comb
    begin
        if (integ_sum[SUM_W-1] != integ_sum[SUM_W-2])
            integ_next = integ_sum[SUM_W-1] ? INTEG_MIN : INTEG_MAX;
        else
            integ_next = integ_sum[INTEG_W-1:0];
    end

    assign diff_next = {err_reg[ERR_W-1], err_reg} - {prev_reg[ERR_W-1], prev_reg};

    // shared multiplier operand select
    assign mul_issue = (state_reg == S_MUL) && (mcnt_reg < MUL_STEPS);
    assign op_issue  = mul_op_t'(mcnt_reg);

    always_comb
    begin
        unique case (op_issue)
            OP_DER:
            begin
                mul_a = {{(MUL_A_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                mul_b = {{(MUL_B_W-RATE_W){1'b0}}, freq};
            end
            OP_P:
            begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
            OP_IL:
            begin
                mul_a = gain_i_reg;
                mul_b = {1'b0, integ_reg[HALF_W-1:0]};
            end
            OP_IH:
            begin
                mul_a = gain_i_reg;
                mul_b = {integ_reg[INTEG_W-1], integ_reg[INTEG_W-1:HALF_W]};
            end
            OP_DL:
            begin
                mul_a = gain_d_reg;
                mul_b = {1'b0, deriv_reg[HALF_W-1:0]};
            end
            OP_DH:
            begin
                mul_a = gain_d_reg;
                mul_b = {{(MUL_B_W-DERIV_W+HALF_W){deriv_reg[DERIV_W-1]}},
                         deriv_reg[DERIV_W-1:HALF_W]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // weight the registered product by its place in the wide sum
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        unique case (prod_op_reg)
            OP_P:    term = prod_ext << SPD_SHIFT;
            OP_IL:   term = prod_ext;
            OP_IH:   term = prod_ext << HALF_W;
            OP_DL:   term = prod_ext << SPD_SHIFT;
            OP_DH:   term = prod_ext << (HALF_W + SPD_SHIFT);
            default: term = '0;
        endcase
    end

    assign acc_next = acc_reg + term;

    // truncate toward zero, then clamp
    assign mag     = acc_reg[ACC_W-1:OUT_SHIFT];
    assign over    = (|mag[MAG_W-1:LIMIT_W]) || (mag[LIMIT_W-1:0] > limit_reg);
    assign mag_eff = over ? limit_reg : mag[LIMIT_W-1:0];
    assign eff_pos = {1'b0, mag_eff};
    assign effort_next = neg_reg ? -eff_pos : eff_pos;

    always_comb
    begin
        if (!over)
            clamp_next = CLAMP_NONE;
        else if (neg_reg)
            clamp_next = CLAMP_LOW;
        else
            clamp_next = CLAMP_HIGH;
    end

    // sequencer, configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dcnt_reg      <= '0;
            mcnt_reg      <= '0;
            prod_vld_reg  <= 1'b0;
            prod_op_reg   <= OP_DER;
            out_valid_reg <= 1'b0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            rate_reg      <= RATE_RESET;
            limit_reg     <= LIMIT_RESET;
            integ_reg     <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_acc)
                    begin
                        if (sample.clear)
                        begin
                            integ_reg <= '0;
                            prev_reg  <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            dcnt_reg  <= DCNT_W'(DIV_W - 1);
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == '0)
                        state_reg <= S_INTEG;
                end
                S_INTEG:
                begin
                    integ_reg    <= integ_next;
                    prev_reg     <= err_reg;
                    mcnt_reg     <= '0;
                    prod_vld_reg <= 1'b0;
                    state_reg    <= S_MUL;
                end
                S_MUL:
                begin
                    mcnt_reg     <= mcnt_reg + 1'b1;
                    prod_vld_reg <= mul_issue;
                    prod_op_reg  <= op_issue;
                    if (mcnt_reg == MUL_STEPS)
                        state_reg <= S_ABS;
                end
                S_ABS:
                begin
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // writes must come only while idle (the block does not check); a listed register also clears the loop
            if (cfg_acc)
            begin
                unique case (cfg.addr)
                    REG_GAIN_P:       gain_p_reg <= cfg.data;
                    REG_GAIN_I:       gain_i_reg <= cfg.data;
                    REG_GAIN_D:       gain_d_reg <= cfg.data;
                    REG_LOOP_RATE:    rate_reg   <= cfg.data[RATE_W-1:0];
                    REG_EFFORT_LIMIT: limit_reg  <= cfg.data[LIMIT_W-1:0];
                    default:          ;
                endcase
                if (cfg.addr <= REG_EFFORT_LIMIT)
                begin
                    integ_reg <= '0;
                    prev_reg  <= '0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                err_reg        <= err_in;
                div_reg        <= div_load;
                rem_reg        <= '0;
                res_effort_reg <= '0;
                res_err_reg    <= '0;
                res_clamp_reg  <= CLAMP_NONE;
            end
            S_DIV:
            begin
                div_reg <= div_next;
                rem_reg <= rem_next;
            end
            S_INTEG:
            begin
                diff_reg <= diff_next;
                acc_reg  <= '0;
            end
            S_MUL:
            begin
                prod_reg <= prod_next;
                if (prod_vld_reg)
                begin
                    if (prod_op_reg == OP_DER)
                        deriv_reg <= prod_reg[DERIV_W-1:0];
                    else
                        acc_reg <= acc_next;
                end
            end
            S_ABS:
            begin
                neg_reg <= acc_reg[ACC_W-1];
                acc_reg <= acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
            end
            S_CLAMP:
            begin
                res_effort_reg <= effort_next;
                res_err_reg    <= err_reg;
                res_clamp_reg  <= clamp_next;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_effort_reg <= res_effort_reg;
                    out_err_reg    <= res_err_reg;
                    out_clamp_reg  <= res_clamp_reg;
                end
            end
            default:
            begin
                rem_reg <= '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/psc_checker.sv */
// Port-level checks of the PID speed controller, bound to the top level.
// Depends on psc_pkg for the clamp codes and field widths.
`timescale 1ns / 1ps
`default_nettype none

module psc_checker
    import psc_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                r_valid,
    input wire logic                r_ready,
    input wire logic [EFFORT_W-1:0] r_effort,
    input wire logic [ERR_W-1:0]    r_err,
    input wire logic [CLAMP_W-1:0]  r_clamp
);

    // one word in flight: the sample side closes right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sample ready high right after a word was taken");

    a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (r_clamp == CLAMP_NONE || r_clamp == CLAMP_HIGH
                     || r_clamp == CLAMP_LOW))
        else $error("clamp flag holds an unused code");

    // a clamped effort sits on the side of its flag
    a_clamp_sign: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> !((r_clamp == CLAMP_HIGH && r_effort[EFFORT_W-1])
                      || (r_clamp == CLAMP_LOW && r_effort != '0
                          && !r_effort[EFFORT_W-1])))
        else $error("drive effort sign disagrees with clamp flag");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && !r_ready) |=> (r_valid && $stable(r_effort)
                                   && $stable(r_err) && $stable(r_clamp)))
        else $error("stalled result word changed");

endmodule

bind pid_speed_controller_top psc_checker u_psc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (sample.valid),
    .s_ready  (sample.ready),
    .r_valid  (result.valid),
    .r_ready  (result.ready),
    .r_effort (result.drive_effort),
    .r_err    (result.speed_error),
    .r_clamp  (result.clamp_state)
);

`default_nettype wire
